// File: rtl/aabb_quaternion_rotate_macros.svh
// ----------------------------------------------------------------------------
// aabb quaternion rotate assertion macros
// shared concurrent assertion shorthands for the rotated box block
// ----------------------------------------------------------------------------
`ifndef AABB_QUATERNION_ROTATE_MACROS_SVH
`define AABB_QUATERNION_ROTATE_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define AQR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds at every clock edge out of reset
`define AQR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// File: rtl/aqr_pkg.sv
// ----------------------------------------------------------------------------
// aqr_pkg
// widths, beat types and the rounding helper of the rotated box pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package aqr_pkg;

  localparam int unsigned CoordWidth = 24;
  localparam int unsigned QuatWidth  = 16;
  localparam int unsigned QuatFrac   = QuatWidth - 2;
  localparam int unsigned RoundShift = 2 * QuatFrac;
  localparam int unsigned ProdWidth  = 2 * QuatWidth;
  localparam int unsigned MatWidth   = ProdWidth + 2;
  localparam int unsigned TermWidth  = MatWidth + CoordWidth;
  localparam int unsigned SumWidth   = TermWidth + 2;
  localparam int unsigned Latency    = 6;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [QuatWidth-1:0]  quat_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [MatWidth-1:0]   mat_t;
  typedef logic signed [TermWidth-1:0]  term_t;
  typedef logic signed [SumWidth-1:0]   sum_t;

  typedef struct packed {
    quat_t  quat_w;
    quat_t  quat_x;
    quat_t  quat_y;
    quat_t  quat_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } aqr_in_t;

  typedef struct packed {
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;
  } aqr_out_t;

  // round to nearest with ties up, then saturate to the coordinate range
  function automatic coord_t round_sat(sum_t s);
    sum_t rnd;
    sum_t shf;
    sum_t sat_hi;
    sum_t sat_lo;
    coord_t res;
    rnd    = s + (sum_t'(1) <<< (RoundShift - 1));
    shf    = rnd >>> RoundShift;
    sat_hi = {{(SumWidth - CoordWidth + 1){1'b0}}, {(CoordWidth - 1){1'b1}}};
    sat_lo = ~sat_hi;
    if (shf > sat_hi) begin
      res = sat_hi[CoordWidth-1:0];
    end else if (shf < sat_lo) begin
      res = sat_lo[CoordWidth-1:0];
    end else begin
      res = shf[CoordWidth-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/aqr_matrix.sv
// ----------------------------------------------------------------------------
// aqr_matrix
// two stages: quaternion pair products, then the nine rotation matrix entries
// ----------------------------------------------------------------------------
`default_nettype none

module aqr_matrix (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire aqr_pkg::aqr_in_t req_i,
  output logic                 valid_o,
  output aqr_pkg::mat_t        mat_o [9],
  output aqr_pkg::coord_t      lo_o  [3],
  output aqr_pkg::coord_t      hi_o  [3]
);

  import aqr_pkg::*;

  // ww xx yy zz xy wz xz wy yz wx
  prod_t  prod_d [10];
  prod_t  prod_q [10];
  coord_t lo1_q  [3];
  coord_t hi1_q  [3];
  logic   valid1_q;

  mat_t   mat_d  [9];
  mat_t   mat_q  [9];
  coord_t lo2_q  [3];
  coord_t hi2_q  [3];
  logic   valid2_q;

  mat_t ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;

  always_comb begin
    prod_d[0] = req_i.quat_w * req_i.quat_w;
    prod_d[1] = req_i.quat_x * req_i.quat_x;
    prod_d[2] = req_i.quat_y * req_i.quat_y;
    prod_d[3] = req_i.quat_z * req_i.quat_z;
    prod_d[4] = req_i.quat_x * req_i.quat_y;
    prod_d[5] = req_i.quat_w * req_i.quat_z;
    prod_d[6] = req_i.quat_x * req_i.quat_z;
    prod_d[7] = req_i.quat_w * req_i.quat_y;
    prod_d[8] = req_i.quat_y * req_i.quat_z;
    prod_d[9] = req_i.quat_w * req_i.quat_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    lo1_q[0] <= req_i.box_min_x;
    lo1_q[1] <= req_i.box_min_y;
    lo1_q[2] <= req_i.box_min_z;
    hi1_q[0] <= req_i.box_max_x;
    hi1_q[1] <= req_i.box_max_y;
    hi1_q[2] <= req_i.box_max_z;
    mat_q    <= mat_d;
    lo2_q    <= lo1_q;
    hi2_q    <= hi1_q;
  end

  always_comb begin
    ww = MatWidth'(prod_q[0]);
    xx = MatWidth'(prod_q[1]);
    yy = MatWidth'(prod_q[2]);
    zz = MatWidth'(prod_q[3]);
    xy = MatWidth'(prod_q[4]);
    wz = MatWidth'(prod_q[5]);
    xz = MatWidth'(prod_q[6]);
    wy = MatWidth'(prod_q[7]);
    yz = MatWidth'(prod_q[8]);
    wx = MatWidth'(prod_q[9]);
    mat_d[0] = ww + xx - yy - zz;
    mat_d[1] = (xy - wz) <<< 1;
    mat_d[2] = (xz + wy) <<< 1;
    mat_d[3] = (xy + wz) <<< 1;
    mat_d[4] = ww - xx + yy - zz;
    mat_d[5] = (yz - wx) <<< 1;
    mat_d[6] = (xz - wy) <<< 1;
    mat_d[7] = (yz + wx) <<< 1;
    mat_d[8] = ww - xx - yy + zz;
  end

  assign valid_o = valid2_q;
  assign mat_o   = mat_q;
  assign lo_o    = lo2_q;
  assign hi_o    = hi2_q;

endmodule

`default_nettype wire

// File: rtl/aqr_project.sv
// ----------------------------------------------------------------------------
// aqr_project
// two stages: matrix entry times both box bounds, then per-term min and max
// ----------------------------------------------------------------------------
`default_nettype none

module aqr_project (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire aqr_pkg::mat_t   mat_i  [9],
  input  wire aqr_pkg::coord_t lo_i   [3],
  input  wire aqr_pkg::coord_t hi_i   [3],
  output logic                 valid_o,
  output aqr_pkg::term_t       tmin_o [9],
  output aqr_pkg::term_t       tmax_o [9]
);

  import aqr_pkg::*;

  term_t plo_d  [9];
  term_t phi_d  [9];
  term_t plo_q  [9];
  term_t phi_q  [9];
  logic  valid3_q;

  term_t tmin_d [9];
  term_t tmax_d [9];
  term_t tmin_q [9];
  term_t tmax_q [9];
  logic  valid4_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        plo_d[c*3+k] = mat_i[c*3+k] * lo_i[k];
        phi_d[c*3+k] = mat_i[c*3+k] * hi_i[k];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 9; r++) begin
      if (plo_q[r] < phi_q[r]) begin
        tmin_d[r] = plo_q[r];
        tmax_d[r] = phi_q[r];
      end else begin
        tmin_d[r] = phi_q[r];
        tmax_d[r] = plo_q[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    tmin_q <= tmin_d;
    tmax_q <= tmax_d;
  end

  assign valid_o = valid4_q;
  assign tmin_o  = tmin_q;
  assign tmax_o  = tmax_q;

endmodule

`default_nettype wire

// File: rtl/aqr_reduce.sv
// ----------------------------------------------------------------------------
// aqr_reduce
// two stages: per-axis sums of extreme terms, then rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module aqr_reduce (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire aqr_pkg::term_t  tmin_i [9],
  input  wire aqr_pkg::term_t  tmax_i [9],
  output logic                 valid_o,
  output aqr_pkg::aqr_out_t    res_o
);

  import aqr_pkg::*;

  sum_t     smin_d [3];
  sum_t     smax_d [3];
  sum_t     smin_q [3];
  sum_t     smax_q [3];
  logic     valid5_q;

  aqr_out_t res_d;
  aqr_out_t res_q;
  logic     valid6_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      smin_d[c] = SumWidth'(tmin_i[c*3]) + SumWidth'(tmin_i[c*3+1])
                + SumWidth'(tmin_i[c*3+2]);
      smax_d[c] = SumWidth'(tmax_i[c*3]) + SumWidth'(tmax_i[c*3+1])
                + SumWidth'(tmax_i[c*3+2]);
    end
  end

  always_comb begin
    res_d.out_min_x = round_sat(smin_q[0]);
    res_d.out_min_y = round_sat(smin_q[1]);
    res_d.out_min_z = round_sat(smin_q[2]);
    res_d.out_max_x = round_sat(smax_q[0]);
    res_d.out_max_y = round_sat(smax_q[1]);
    res_d.out_max_z = round_sat(smax_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q <= 1'b0;
      valid6_q <= 1'b0;
    end else begin
      valid5_q <= valid_i;
      valid6_q <= valid5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    smin_q <= smin_d;
    smax_q <= smax_d;
    res_q  <= res_d;
  end

  assign valid_o = valid6_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/aabb_quaternion_rotate.sv
// ----------------------------------------------------------------------------
// aabb_quaternion_rotate
// bounding box of an axis-aligned box rotated by a quaternion
// ----------------------------------------------------------------------------
// usage:
//   a beat on req_i (quaternion in Q2.14, box corners with 8 fraction bits)
//   is taken at each rising edge where start_i is high and busy_o is low.
//   busy_o is held low: a new box can be started in every cycle.
//   each result appears on res_o for exactly one cycle with done_o high,
//   once its start beat has passed through every stage, in start order; one result per box.
//   throughput is one box per cycle, set by the six-stage pipeline:
//   quaternion products, matrix entries, entry-times-bound products,
//   per-term min and max, per-axis sums, rounding and saturation.
//   the receiver cannot stall, so no beat is ever held back.
//   reset clears only the stage valid bits; beats in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_quaternion_rotate (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire aqr_pkg::aqr_in_t req_i,
  output logic                  done_o,
  output aqr_pkg::aqr_out_t     res_o
);

  import aqr_pkg::*;

  `include "aabb_quaternion_rotate_macros.svh"

  logic   mat_valid;
  mat_t   mat   [9];
  coord_t lo    [3];
  coord_t hi    [3];

  logic   term_valid;
  term_t  tmin  [9];
  term_t  tmax  [9];

  logic   min_le_max;
  logic   term_order_ok;

  assign busy_o = 1'b0;

  aqr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .req_i   (req_i),
    .valid_o (mat_valid),
    .mat_o   (mat),
    .lo_o    (lo),
    .hi_o    (hi)
  );

  aqr_project u_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mat_valid),
    .mat_i   (mat),
    .lo_i    (lo),
    .hi_i    (hi),
    .valid_o (term_valid),
    .tmin_o  (tmin),
    .tmax_o  (tmax)
  );

  aqr_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_valid),
    .tmin_i  (tmin),
    .tmax_i  (tmax),
    .valid_o (done_o),
    .res_o   (res_o)
  );

  assign min_le_max = (res_o.out_min_x <= res_o.out_max_x) &&
                      (res_o.out_min_y <= res_o.out_max_y) &&
                      (res_o.out_min_z <= res_o.out_max_z);

  assign term_order_ok = !term_valid ||
                         (tmin[0] <= tmax[0] && tmin[4] <= tmax[4] && tmin[8] <= tmax[8]);

  `AQR_ASSERT_IMP(a_done_has_start, clk_i, rst_ni, done_o, $past(start_i, Latency), "stray done")
  `AQR_ASSERT_IMP(a_min_le_max, clk_i, rst_ni, done_o, min_le_max, "min above max")
  `AQR_ASSERT_ALWAYS(a_term_order, clk_i, rst_ni, term_order_ok, "term extremes out of order")

endmodule

`default_nettype wire
